>>> rtl/core/dqrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque package
// Shared item types, operation and status codes, and the command and status
// groups that pass between the deque controller and its datapath.
// ----------------------------------------------------------------------------
package dqrs_pkg;

	// Dump never gives out more than this many entries.
	localparam int unsigned MAX_RESULTS = 16;

	// Operation codes carried in the mode field.
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
	localparam logic [2:0] MODE_POP_BACK   = 3'd2;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [2:0] MODE_REMOVE     = 3'd4;
	localparam logic [2:0] MODE_SORT       = 3'd5;
	localparam logic [2:0] MODE_DUMP       = 3'd6;

	// Status codes reported with every result.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] value_in;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [4:0]         count;
		logic signed [31:0] value_out;
		logic               last;
	} rsp_item_t;

	typedef enum logic [1:0] {PTR_HOLD, PTR_INC, PTR_DEC} ptr_op_t;
	typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_INC, IDX_FROM_I} idx_op_t;
	typedef enum logic [1:0] {RSEL_I, RSEL_J, RSEL_J1} rd_sel_t;
	typedef enum logic [2:0] {WSEL_BACK, WSEL_FRONT, WSEL_J, WSEL_I, WSEL_MIN} wr_sel_t;
	typedef enum logic [1:0] {WDAT_VALUE, WDAT_RDATA, WDAT_CUR, WDAT_MIN} wr_dat_t;

	typedef struct packed {
		logic       latch;
		ptr_op_t    head_op;
		ptr_op_t    cnt_op;
		idx_op_t    i_op;
		idx_op_t    j_op;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       wr_en;
		wr_sel_t    wr_sel;
		wr_dat_t    wr_dat;
		logic       sort_init;
		logic       min_take;
		logic       emit;
		logic [1:0] emit_status;
		logic       emit_data;
		logic       emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       empty;
		logic       full;
		logic       match;
		logic       less;
		logic       j_end;
		logic       j1_end;
		logic       i1_end;
		logic       dump_last;
		logic       out_free;
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RM_RD,
		ST_RM_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_SO_RI,
		ST_SO_LI,
		ST_SO_RJ,
		ST_SO_CJ,
		ST_SO_W1,
		ST_SO_W2,
		ST_DP_RD,
		ST_DP_EM
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/dqrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dqrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/dqrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque controller
// Sequences each operation over the datapath: dispatch, scans, shifts,
// selection sort passes and dump reads.
// ----------------------------------------------------------------------------
module dqrs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire dqrs_pkg::dp_stat_t stat,
	output dqrs_pkg::dp_cmd_t       dp_cmd
);

	dqrs_pkg::state_t state_q;
	dqrs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_stall = (state_q != dqrs_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		case (state_q)
			dqrs_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					dp_cmd.latch = 1'b1;
					state_d      = dqrs_pkg::ST_EXEC;
				end
			end
			dqrs_pkg::ST_EXEC: begin
				case (stat.mode)
					dqrs_pkg::MODE_PUSH_BACK, dqrs_pkg::MODE_PUSH_FRONT: begin
						if (stat.out_free) begin
							dp_cmd.emit      = 1'b1;
							dp_cmd.emit_last = 1'b1;
							state_d          = dqrs_pkg::ST_IDLE;
							if (stat.full) begin
								dp_cmd.emit_status = dqrs_pkg::STAT_FULL;
							end else begin
								dp_cmd.wr_en  = 1'b1;
								dp_cmd.wr_dat = dqrs_pkg::WDAT_VALUE;
								dp_cmd.cnt_op = dqrs_pkg::PTR_INC;
								if (stat.mode == dqrs_pkg::MODE_PUSH_FRONT) begin
									dp_cmd.wr_sel  = dqrs_pkg::WSEL_FRONT;
									dp_cmd.head_op = dqrs_pkg::PTR_DEC;
								end else begin
									dp_cmd.wr_sel = dqrs_pkg::WSEL_BACK;
								end
							end
						end
					end
					dqrs_pkg::MODE_POP_BACK, dqrs_pkg::MODE_POP_FRONT: begin
						if (stat.out_free) begin
							dp_cmd.emit      = 1'b1;
							dp_cmd.emit_last = 1'b1;
							state_d          = dqrs_pkg::ST_IDLE;
							if (stat.empty) begin
								dp_cmd.emit_status = dqrs_pkg::STAT_EMPTY;
							end else begin
								dp_cmd.cnt_op = dqrs_pkg::PTR_DEC;
								if (stat.mode == dqrs_pkg::MODE_POP_FRONT) begin
									dp_cmd.head_op = dqrs_pkg::PTR_INC;
								end
							end
						end
					end
					dqrs_pkg::MODE_REMOVE, dqrs_pkg::MODE_SORT, dqrs_pkg::MODE_DUMP: begin
						if (stat.empty) begin
							if (stat.out_free) begin
								dp_cmd.emit        = 1'b1;
								dp_cmd.emit_last   = 1'b1;
								dp_cmd.emit_status = dqrs_pkg::STAT_EMPTY;
								state_d            = dqrs_pkg::ST_IDLE;
							end
						end else if (stat.mode == dqrs_pkg::MODE_REMOVE) begin
							dp_cmd.j_op = dqrs_pkg::IDX_ZERO;
							state_d     = dqrs_pkg::ST_RM_RD;
						end else if (stat.mode == dqrs_pkg::MODE_SORT) begin
							dp_cmd.i_op = dqrs_pkg::IDX_ZERO;
							state_d     = dqrs_pkg::ST_SO_RI;
						end else begin
							dp_cmd.i_op = dqrs_pkg::IDX_ZERO;
							state_d     = dqrs_pkg::ST_DP_RD;
						end
					end
					default: begin
						// The unused code changes nothing and reports ok.
						if (stat.out_free) begin
							dp_cmd.emit      = 1'b1;
							dp_cmd.emit_last = 1'b1;
							state_d          = dqrs_pkg::ST_IDLE;
						end
					end
				endcase
			end
			dqrs_pkg::ST_RM_RD: begin
				dp_cmd.rd_en  = 1'b1;
				dp_cmd.rd_sel = dqrs_pkg::RSEL_J;
				state_d       = dqrs_pkg::ST_RM_CMP;
			end
			dqrs_pkg::ST_RM_CMP: begin
				if (stat.match) begin
					state_d = dqrs_pkg::ST_SH_RD;
				end else if (stat.j1_end) begin
					if (stat.out_free) begin
						dp_cmd.emit        = 1'b1;
						dp_cmd.emit_last   = 1'b1;
						dp_cmd.emit_status = dqrs_pkg::STAT_NOT_FOUND;
						state_d            = dqrs_pkg::ST_IDLE;
					end
				end else begin
					dp_cmd.j_op = dqrs_pkg::IDX_INC;
					state_d     = dqrs_pkg::ST_RM_RD;
				end
			end
			dqrs_pkg::ST_SH_RD: begin
				if (stat.j1_end) begin
					if (stat.out_free) begin
						dp_cmd.cnt_op    = dqrs_pkg::PTR_DEC;
						dp_cmd.emit      = 1'b1;
						dp_cmd.emit_last = 1'b1;
						state_d          = dqrs_pkg::ST_IDLE;
					end
				end else begin
					dp_cmd.rd_en  = 1'b1;
					dp_cmd.rd_sel = dqrs_pkg::RSEL_J1;
					state_d       = dqrs_pkg::ST_SH_WR;
				end
			end
			dqrs_pkg::ST_SH_WR: begin
				dp_cmd.wr_en  = 1'b1;
				dp_cmd.wr_sel = dqrs_pkg::WSEL_J;
				dp_cmd.wr_dat = dqrs_pkg::WDAT_RDATA;
				dp_cmd.j_op   = dqrs_pkg::IDX_INC;
				state_d       = dqrs_pkg::ST_SH_RD;
			end
			dqrs_pkg::ST_SO_RI: begin
				if (stat.i1_end) begin
					if (stat.out_free) begin
						dp_cmd.emit      = 1'b1;
						dp_cmd.emit_last = 1'b1;
						state_d          = dqrs_pkg::ST_IDLE;
					end
				end else begin
					dp_cmd.rd_en  = 1'b1;
					dp_cmd.rd_sel = dqrs_pkg::RSEL_I;
					state_d       = dqrs_pkg::ST_SO_LI;
				end
			end
			dqrs_pkg::ST_SO_LI: begin
				dp_cmd.sort_init = 1'b1;
				dp_cmd.j_op      = dqrs_pkg::IDX_FROM_I;
				state_d          = dqrs_pkg::ST_SO_RJ;
			end
			dqrs_pkg::ST_SO_RJ: begin
				if (stat.j_end) begin
					state_d = dqrs_pkg::ST_SO_W1;
				end else begin
					dp_cmd.rd_en  = 1'b1;
					dp_cmd.rd_sel = dqrs_pkg::RSEL_J;
					state_d       = dqrs_pkg::ST_SO_CJ;
				end
			end
			dqrs_pkg::ST_SO_CJ: begin
				dp_cmd.min_take = stat.less;
				dp_cmd.j_op     = dqrs_pkg::IDX_INC;
				state_d         = dqrs_pkg::ST_SO_RJ;
			end
			dqrs_pkg::ST_SO_W1: begin
				dp_cmd.wr_en  = 1'b1;
				dp_cmd.wr_sel = dqrs_pkg::WSEL_MIN;
				dp_cmd.wr_dat = dqrs_pkg::WDAT_CUR;
				state_d       = dqrs_pkg::ST_SO_W2;
			end
			dqrs_pkg::ST_SO_W2: begin
				dp_cmd.wr_en  = 1'b1;
				dp_cmd.wr_sel = dqrs_pkg::WSEL_I;
				dp_cmd.wr_dat = dqrs_pkg::WDAT_MIN;
				dp_cmd.i_op   = dqrs_pkg::IDX_INC;
				state_d       = dqrs_pkg::ST_SO_RI;
			end
			dqrs_pkg::ST_DP_RD: begin
				dp_cmd.rd_en  = 1'b1;
				dp_cmd.rd_sel = dqrs_pkg::RSEL_I;
				state_d       = dqrs_pkg::ST_DP_EM;
			end
			dqrs_pkg::ST_DP_EM: begin
				if (stat.out_free) begin
					dp_cmd.emit      = 1'b1;
					dp_cmd.emit_data = 1'b1;
					dp_cmd.emit_last = stat.dump_last;
					if (stat.dump_last) begin
						state_d = dqrs_pkg::ST_IDLE;
					end else begin
						dp_cmd.i_op = dqrs_pkg::IDX_INC;
						state_d     = dqrs_pkg::ST_DP_RD;
					end
				end
			end
			default: begin
				state_d = dqrs_pkg::ST_IDLE;
			end
		endcase
	end

	// A transfer on the command channel always starts the dispatch state.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> state_q == dqrs_pkg::ST_EXEC)
		else $error("accepted command did not reach dispatch");

endmodule
`default_nettype wire

>>> rtl/core/dqrs_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque datapath
// Ring pointers, scan indexes, sort registers, entry RAM and the result
// register, all driven by the controller's command group.
// ----------------------------------------------------------------------------
module dqrs_dpath #(
	parameter int CAPACITY = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dqrs_pkg::cmd_item_t cmd,
	input  wire logic                rsp_stall,
	output logic                     rsp_valid,
	output dqrs_pkg::rsp_item_t      rsp,
	input  wire dqrs_pkg::dp_cmd_t   dp_cmd,
	output dqrs_pkg::dp_stat_t       stat
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = $clog2(2 * CAPACITY);
	localparam int XW = ((CW > 5) ? CW : 5) + 1;

	logic [AW-1:0]      head_q, head_d, head_dec, head_inc;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      i_q, i_d, j_q, j_d, min_idx_q;
	logic [2:0]         mode_q;
	logic signed [31:0] value_q, cur_q, min_q;
	logic signed [31:0] rdata;
	logic [31:0]        wdata;
	logic [AW-1:0]      raddr, waddr;
	logic [XW-1:0]      i_nx, j_nx, cnt_x;
	logic               rsp_valid_q;
	dqrs_pkg::rsp_item_t rsp_q;
	logic               out_free;

	// Ring position of the entry at logical place x from the front.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] x);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(x);
		if (s >= SW'(CAPACITY)) begin
			s = s - SW'(CAPACITY);
		end
		return AW'(s);
	endfunction

	assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
	assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		case (dp_cmd.head_op)
			dqrs_pkg::PTR_INC: head_d = head_inc;
			dqrs_pkg::PTR_DEC: head_d = head_dec;
			default:           head_d = head_q;
		endcase
		case (dp_cmd.cnt_op)
			dqrs_pkg::PTR_INC: count_d = count_q + 1'b1;
			dqrs_pkg::PTR_DEC: count_d = count_q - 1'b1;
			default:           count_d = count_q;
		endcase
		case (dp_cmd.i_op)
			dqrs_pkg::IDX_ZERO: i_d = '0;
			dqrs_pkg::IDX_INC:  i_d = i_q + 1'b1;
			default:            i_d = i_q;
		endcase
		case (dp_cmd.j_op)
			dqrs_pkg::IDX_ZERO:   j_d = '0;
			dqrs_pkg::IDX_INC:    j_d = j_q + 1'b1;
			dqrs_pkg::IDX_FROM_I: j_d = i_q + 1'b1;
			default:              j_d = j_q;
		endcase
	end

	always_comb begin
		case (dp_cmd.rd_sel)
			dqrs_pkg::RSEL_J:  raddr = slot_of(head_q, j_q);
			dqrs_pkg::RSEL_J1: raddr = slot_of(head_q, j_q + 1'b1);
			default:           raddr = slot_of(head_q, i_q);
		endcase
		case (dp_cmd.wr_sel)
			dqrs_pkg::WSEL_BACK:  waddr = slot_of(head_q, count_q);
			dqrs_pkg::WSEL_FRONT: waddr = head_dec;
			dqrs_pkg::WSEL_J:     waddr = slot_of(head_q, j_q);
			dqrs_pkg::WSEL_MIN:   waddr = slot_of(head_q, min_idx_q);
			default:              waddr = slot_of(head_q, i_q);
		endcase
		case (dp_cmd.wr_dat)
			dqrs_pkg::WDAT_RDATA: wdata = rdata;
			dqrs_pkg::WDAT_CUR:   wdata = cur_q;
			dqrs_pkg::WDAT_MIN:   wdata = min_q;
			default:              wdata = value_q;
		endcase
	end

	dqrs_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (dp_cmd.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.re    (dp_cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			if (dp_cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d;
		j_q <= j_d;
		if (dp_cmd.latch) begin
			mode_q  <= cmd.mode;
			value_q <= cmd.value_in;
		end
		if (dp_cmd.sort_init) begin
			cur_q     <= rdata;
			min_q     <= rdata;
			min_idx_q <= i_q;
		end else if (dp_cmd.min_take) begin
			min_q     <= rdata;
			min_idx_q <= j_q;
		end
		if (dp_cmd.emit) begin
			rsp_q.status    <= dp_cmd.emit_status;
			rsp_q.count     <= 5'(count_d);
			rsp_q.value_out <= dp_cmd.emit_data ? rdata : '0;
			rsp_q.last      <= dp_cmd.emit_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign i_nx  = XW'(i_q) + XW'(1);
	assign j_nx  = XW'(j_q) + XW'(1);
	assign cnt_x = XW'(count_q);

	always_comb begin
		stat.mode      = mode_q;
		stat.empty     = (count_q == '0);
		stat.full      = (count_q >= CW'(CAPACITY));
		stat.match     = (rdata == value_q);
		stat.less      = (rdata < min_q);
		stat.j_end     = (j_q == count_q);
		stat.j1_end    = (j_nx == cnt_x);
		stat.i1_end    = (i_nx >= cnt_x);
		stat.dump_last = (i_nx == cnt_x) || (i_nx == XW'(dqrs_pkg::MAX_RESULTS));
		stat.out_free  = out_free;
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n) head_q <= AW'(CAPACITY - 1))
		else $error("head pointer outside the ring");

	// A new result may only be loaded when the held one is gone or leaving.
	assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.emit |-> (!rsp_valid_q || !rsp_stall))
		else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

>>> rtl/core/deque_with_remove_and_sort.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue with remove and sort
// Bounded ring of signed 32-bit entries with push and pop at both ends,
// remove of the first match, in-place selection sort and a front-to-back dump.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                   Moves per transfer
//   cmd       cmd_valid, cmd_stall, cmd one operation: mode and value_in
//   rsp       rsp_valid, rsp_stall, rsp one result: status, count, value_out, last
//
// Pushes, pops and the unused code pass from the transfer to the execute
// state, which updates the ring and loads the result register.
// Remove scans with a read state and a compare state per entry and shifts
// the tail behind a match with a read state and a write state per entry,
// set by the single RAM read port and its registered read data. Sort runs
// n - 1 passes over a ring of n entries, each reading and loading the pass
// entry, scanning the entries behind it and writing the swap back; dump
// reads and gives out one entry at a time.
// Reset clears the head pointer, the entry count and the result valid; the
// entry RAM is not cleared. A stalled result holds the controller in place.
// Commands are taken only while no operation is in progress, but a command
// may be taken while the last result of the previous one still waits.
//
module deque_with_remove_and_sort #(
	parameter int CAPACITY = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire dqrs_pkg::cmd_item_t cmd,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output dqrs_pkg::rsp_item_t      rsp
);

	// The controller sees only the status group and drives only the command group.
	dqrs_pkg::dp_cmd_t  dp_cmd;
	dqrs_pkg::dp_stat_t dp_stat;

	dqrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.stat      (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	// The datapath owns the ring, the entry RAM and the result register.
	dqrs_dpath #(
		.CAPACITY(CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.dp_cmd    (dp_cmd),
		.stat      (dp_stat)
	);

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque with remove and sort: self-checking testbench
// Drives operations into the command channel and predicts every result with
// a software copy of the ring, then checks each result transfer field by
// field in arrival order. Directed tests cover the empty and full store and
// both ends. Random traffic runs under three idling patterns, with one long
// result hold-off and full drains in between.
// ----------------------------------------------------------------------------
module testbench;

	localparam int RING_DEPTH = 16;
	// The mode field has one code that names no operation; the block must
	// answer it with a plain ok result and leave the store alone.
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_NEG_ONE = 32'shFFFF_FFFF;

	// The longest operation is a sort of a full ring. The quiet limit allows
	// for that, for the long hold-off of the result channel and for random
	// stalls, several times over.
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	dqrs_pkg::cmd_item_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	dqrs_pkg::rsp_item_t rsp;

	// Percent of cycles in which the sender idles and the receiver stalls.
	int send_idle_pct = 0;
	int stall_pct = 0;

	// A test asks for a long hold-off by bumping the request count; the
	// receiver process counts the stretch out on its own.
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	int fail_count = 0;
	int quiet_cycles = 0;

	// Predicted contents of the ring: values, front position and fill level.
	logic signed [31:0] ring [RING_DEPTH];
	int head_pos = 0;
	int held = 0;

	// Results predicted for accepted operations, oldest first.
	dqrs_pkg::rsp_item_t pending_results[$];

	deque_with_remove_and_sort #(
		.CAPACITY(RING_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic int slot(input int k);
		return (head_pos + k) % RING_DEPTH;
	endfunction

	task automatic push_expected(input logic [1:0] status, input logic signed [31:0] value,
			input logic fin);
		dqrs_pkg::rsp_item_t r;
		r.status = status;
		r.count = held[4:0];
		r.value_out = value;
		r.last = fin;
		pending_results.insert(pending_results.size(), r);
	endtask

	// Applies one accepted operation to the predicted ring and queues the
	// results it must produce. The count in every result is the fill level
	// after the operation has taken effect.
	task automatic predict_deque_op(input dqrs_pkg::cmd_item_t item);
		logic [1:0] st;
		logic signed [31:0] t;
		int i;
		int j;
		int m;
		int n;
		st = dqrs_pkg::STAT_OK;
		case (item.mode)
			dqrs_pkg::MODE_PUSH_BACK: begin
				if (held >= RING_DEPTH) begin
					st = dqrs_pkg::STAT_FULL;
				end else begin
					ring[slot(held)] = item.value_in;
					held++;
				end
			end
			dqrs_pkg::MODE_PUSH_FRONT: begin
				if (held >= RING_DEPTH) begin
					st = dqrs_pkg::STAT_FULL;
				end else begin
					head_pos = (head_pos + RING_DEPTH - 1) % RING_DEPTH;
					ring[head_pos] = item.value_in;
					held++;
				end
			end
			dqrs_pkg::MODE_POP_BACK: begin
				if (held == 0) st = dqrs_pkg::STAT_EMPTY;
				else held--;
			end
			dqrs_pkg::MODE_POP_FRONT: begin
				if (held == 0) begin
					st = dqrs_pkg::STAT_EMPTY;
				end else begin
					head_pos = (head_pos + 1) % RING_DEPTH;
					held--;
				end
			end
			dqrs_pkg::MODE_REMOVE: begin
				if (held == 0) begin
					st = dqrs_pkg::STAT_EMPTY;
				end else begin
					// Only the first match from the front goes; the tail
					// behind it closes up by one place.
					i = 0;
					while (i < held && ring[slot(i)] != item.value_in) i++;
					if (i == held) begin
						st = dqrs_pkg::STAT_NOT_FOUND;
					end else begin
						for (j = i; j + 1 < held; j++) ring[slot(j)] = ring[slot(j + 1)];
						held--;
					end
				end
			end
			dqrs_pkg::MODE_SORT: begin
				if (held == 0) begin
					st = dqrs_pkg::STAT_EMPTY;
				end else begin
					for (i = 0; i + 1 < held; i++) begin
						m = i;
						for (j = i + 1; j < held; j++)
							if (ring[slot(j)] < ring[slot(m)]) m = j;
						t = ring[slot(i)];
						ring[slot(i)] = ring[slot(m)];
						ring[slot(m)] = t;
					end
				end
			end
			dqrs_pkg::MODE_DUMP: begin
				if (held == 0) begin
					st = dqrs_pkg::STAT_EMPTY;
				end else begin
					n = (held > dqrs_pkg::MAX_RESULTS) ? dqrs_pkg::MAX_RESULTS : held;
					for (i = 0; i < n; i++)
						push_expected(dqrs_pkg::STAT_OK, ring[slot(i)], i + 1 == n);
					return;
				end
			end
			default: begin
			end
		endcase
		push_expected(st, '0, 1'b1);
	endtask

	task automatic check_result(input dqrs_pkg::rsp_item_t got);
		dqrs_pkg::rsp_item_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result: status %0d, count %0d, value_out %0d, last %0b",
				got.status, got.count, got.value_out, got.last);
			fail_count++;
			return;
		end
		want = pending_results[0];
		pending_results.delete(0);
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fail_count++;
		end
		if (got.count !== want.count) begin
			$error("count: expected %0d, got %0d", want.count, got.count);
			fail_count++;
		end
		if (got.value_out !== want.value_out) begin
			$error("value_out: expected %0d, got %0d", want.value_out, got.value_out);
			fail_count++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0b, got %0b", want.last, got.last);
			fail_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor and watchdog
	// ------------------------------------------------------------------

	// Both channels are sampled at the rising edge, where the block's outputs
	// still hold the values of the cycle that is ending. The result is
	// checked before the new operation is predicted; a result can never
	// belong to an operation taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) check_result(rsp);
			if (cmd_valid && !cmd_stall) predict_deque_op(cmd);
			if ((rsp_valid && !rsp_stall) || (cmd_valid && !cmd_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Result side: random stalls, or a long hold-off when a test asks for one.
	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Called at a falling edge. Idles at random, offers the operation, holds
	// it until a transfer takes it and returns at the next falling edge, by
	// which time the prediction for it has been made. Valid is left high so
	// that back-to-back operations see no gap.
	task automatic send_item(input logic [2:0] mode, input logic signed [31:0] value);
		dqrs_pkg::cmd_item_t item;
		item.mode = mode;
		item.value_in = value;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		forever begin
			@(posedge clk);
			if (cmd_valid && !cmd_stall) break;
		end
		@(negedge clk);
	endtask

	// Small values make duplicates and matches likely; the extremes probe
	// the signed order; the rest is anything at all.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2, 3: return $signed($urandom_range(4)) - 2;
			4: begin
				case ($urandom_range(4))
					0: return VAL_MAX;
					1: return VAL_MIN;
					2: return VAL_NEG_ONE;
					3: return 32'sd1;
					default: return 32'sd0;
				endcase
			end
			default: return $signed($urandom);
		endcase
	endfunction

	// A value that the ring holds now, so that a remove finds its match.
	function automatic logic signed [31:0] held_value();
		return ring[slot($urandom_range(held - 1))];
	endfunction

	// The sender stops and waits until every predicted result has come.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every operation that needs an entry must report the empty store.
	task automatic test_empty_store();
		send_item(dqrs_pkg::MODE_POP_BACK, VAL_MAX);
		send_item(dqrs_pkg::MODE_POP_FRONT, VAL_MIN);
		send_item(dqrs_pkg::MODE_REMOVE, 32'sd0);
		send_item(dqrs_pkg::MODE_SORT, VAL_NEG_ONE);
		send_item(dqrs_pkg::MODE_DUMP, 32'sd0);
		send_item(MODE_UNUSED, VAL_MAX);
	endtask

	// Pushes at both ends with the signed extremes, a duplicate so that
	// remove must take the first one, a miss, a sort across the sign
	// boundary and pops from both ends.
	task automatic test_both_ends();
		send_item(dqrs_pkg::MODE_PUSH_BACK, VAL_MAX);
		send_item(dqrs_pkg::MODE_PUSH_FRONT, VAL_MIN);
		send_item(dqrs_pkg::MODE_PUSH_BACK, 32'sd0);
		send_item(dqrs_pkg::MODE_PUSH_FRONT, VAL_NEG_ONE);
		send_item(dqrs_pkg::MODE_PUSH_BACK, VAL_MAX);
		send_item(dqrs_pkg::MODE_DUMP, 32'sd0);
		send_item(dqrs_pkg::MODE_REMOVE, VAL_MAX);
		send_item(dqrs_pkg::MODE_REMOVE, 32'sd12345);
		send_item(dqrs_pkg::MODE_SORT, 32'sd0);
		send_item(dqrs_pkg::MODE_DUMP, VAL_MIN);
		send_item(dqrs_pkg::MODE_POP_BACK, 32'sd0);
		send_item(dqrs_pkg::MODE_POP_FRONT, 32'sd0);
	endtask

	// Fills the ring, pushes into the full store at both ends, dumps the
	// longest run of results, then removes, sorts and empties it again.
	task automatic test_full_store();
		while (held < RING_DEPTH)
			send_item($urandom_range(1) ? dqrs_pkg::MODE_PUSH_BACK : dqrs_pkg::MODE_PUSH_FRONT,
				pick_value());
		send_item(dqrs_pkg::MODE_PUSH_BACK, pick_value());
		send_item(dqrs_pkg::MODE_PUSH_FRONT, pick_value());
		send_item(dqrs_pkg::MODE_DUMP, pick_value());
		send_item(dqrs_pkg::MODE_REMOVE, held_value());
		send_item(dqrs_pkg::MODE_SORT, pick_value());
		send_item(dqrs_pkg::MODE_DUMP, pick_value());
		while (held > 0)
			send_item($urandom_range(1) ? dqrs_pkg::MODE_POP_BACK : dqrs_pkg::MODE_POP_FRONT,
				pick_value());
	endtask

	// Random operations. The push share follows the fill level so that the
	// ring keeps moving between nearly empty and full; most removes name a
	// value that is held.
	task automatic test_random_ops(input int num_ops);
		int r;
		int push_w;
		logic [2:0] mode;
		logic signed [31:0] value;
		for (int k = 0; k < num_ops; k++) begin
			push_w = (held < 4) ? 60 : (held > 13) ? 20 : 41;
			r = $urandom_range(push_w + 58);
			if (r < push_w)
				mode = $urandom_range(1) ? dqrs_pkg::MODE_PUSH_BACK : dqrs_pkg::MODE_PUSH_FRONT;
			else if (r < push_w + 20)
				mode = $urandom_range(1) ? dqrs_pkg::MODE_POP_BACK : dqrs_pkg::MODE_POP_FRONT;
			else if (r < push_w + 38) mode = dqrs_pkg::MODE_REMOVE;
			else if (r < push_w + 46) mode = dqrs_pkg::MODE_SORT;
			else if (r < push_w + 56) mode = dqrs_pkg::MODE_DUMP;
			else mode = MODE_UNUSED;
			if (mode == dqrs_pkg::MODE_REMOVE && held > 0 && $urandom_range(3) != 0)
				value = held_value();
			else value = pick_value();
			send_item(mode, value);
		end
	endtask

	// The result channel is held off for a long stretch while the sender
	// keeps offering pushes and dumps with no gaps. The block must fill its
	// result path and stall the command channel without losing anything.
	task automatic test_backpressure();
		int saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		hold_requests++;
		for (int k = 0; k < 24; k++) begin
			if (k % 8 == 7) send_item(dqrs_pkg::MODE_DUMP, pick_value());
			else send_item($urandom_range(1) ? dqrs_pkg::MODE_PUSH_BACK
				: dqrs_pkg::MODE_PUSH_FRONT, pick_value());
		end
		send_idle_pct = saved_idle;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender mostly busy, receiver stalling about half the time.
		send_idle_pct = 10;
		stall_pct = 52;
		test_empty_store();
		test_both_ends();
		test_full_store();
		test_random_ops(95);
		wait_drained();

		// Sender idling about half the time, receiver mostly ready.
		send_idle_pct = 52;
		stall_pct = 10;
		test_backpressure();
		wait_drained();
		test_random_ops(95);
		wait_drained();

		// Full rate on both sides.
		send_idle_pct = 0;
		stall_pct = 0;
		test_random_ops(85);

		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// Any stray result would show up within the longest operation time.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
